// ----- design/zot_pkg.sv -----
// ----------------------------------------------------------------------------
// zot_pkg
// Shared codes, control/status bundles and the free-space classifier.
// ----------------------------------------------------------------------------
package zot_pkg;

	localparam int TDATA_IN_W  = 32;
	localparam int TDATA_OUT_W = 24;
	localparam int CFG_W       = 13;
	localparam int OCC_W       = 11;
	localparam int CAP_W       = 10;
	localparam int MAP_W       = 5;
	localparam int CLS_W       = 16;

	localparam logic [OCC_W-1:0] OCC_MAX = '1;

	// item modes (s_tuser)
	localparam logic [1:0] MODE_EVENT = 2'd0;
	localparam logic [1:0] MODE_MAP   = 2'd1;
	localparam logic [1:0] MODE_CAP   = 2'd2;
	localparam logic [1:0] MODE_OCC   = 2'd3;

	// report kinds (m_tuser)
	localparam logic [1:0] KIND_ECHO  = 2'd0;
	localparam logic [1:0] KIND_ZONE  = 2'd1;
	localparam logic [1:0] KIND_LEVEL = 2'd2;

	// status codes
	localparam logic [1:0] ST_AVAIL = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// config register indexes
	localparam logic CFG_LEVEL_CAP  = 1'b0;
	localparam logic CFG_ZONE_COUNT = 1'b1;

	typedef struct packed {
		logic       capture;   // item accepted this cycle
		logic       ctr_clr;   // zero zone/slot counters and level sum
		logic       slot_adv;  // step the map scan by one slot
		logic       zone_adv;  // step the sum by one zone
		logic       exit_sel;  // scan the exit map
		logic       occ_upd;   // apply +/-1 to the current zone
		logic       emit;      // load the output register
		logic [1:0] kind;
	} cmd_t;

	typedef struct packed {
		logic ev_ok;     // incoming item is a usable detector event
		logic match;     // current map slot holds the event's detector
		logic scan_end;  // last slot of last zone in use
		logic zone_end;  // last zone in use
		logic nz_zero;   // no zones in use
		logic out_free;  // output register can take a beat
	} sts_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [12:0] fc;
	} cls_t;

	function automatic cls_t classify(logic [CLS_W-1:0] cap, logic [CLS_W-1:0] occ);
		cls_t r;
		r.fc = '0;
		if (occ >= cap) begin
			r.st = ST_FULL;
		end else if (occ == '0) begin
			r.st = ST_EMPTY;
		end else begin
			r.st = ST_AVAIL;
			r.fc = 13'(cap - occ);
		end
		return r;
	endfunction

endpackage

// ----- design/zot_ctrl.sv -----
// ----------------------------------------------------------------------------
// zot_ctrl
// Sequencer: echo, entry scan, exit scan, occupancy sum, level report.
// ----------------------------------------------------------------------------
module zot_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  zot_pkg::sts_t sts,
	output zot_pkg::cmd_t cmd
);
	import zot_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		ECHO,
		ENTRY,
		EXIT,
		SUM,
		LEVEL
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign s_tready = (state_q == IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					if (sts.ev_ok) state_nx = ECHO;
				end
			end
			ECHO: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = KIND_ECHO;
					cmd.ctr_clr = 1'b1;
					state_nx    = sts.nz_zero ? LEVEL : ENTRY;
				end
			end
			ENTRY, EXIT: begin
				cmd.exit_sel = (state_q == EXIT);
				// a matching slot waits for room in the output register
				if (!sts.match || sts.out_free) begin
					cmd.slot_adv = 1'b1;
					if (sts.match) begin
						cmd.occ_upd = 1'b1;
						cmd.emit    = 1'b1;
						cmd.kind    = KIND_ZONE;
					end
					if (sts.scan_end) begin
						cmd.ctr_clr = 1'b1;
						state_nx    = (state_q == ENTRY) ? EXIT : SUM;
					end
				end
			end
			SUM: begin
				cmd.zone_adv = 1'b1;
				if (sts.zone_end) state_nx = LEVEL;
			end
			LEVEL: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_LEVEL;
					state_nx = IDLE;
				end
			end
			default: state_nx = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ----- design/zot_dp.sv -----
// ----------------------------------------------------------------------------
// zot_dp
// Zone stores, detector maps, scan counters, level sum and output register.
// ----------------------------------------------------------------------------
module zot_dp #(
	parameter int MAX_ZONES      = 8,
	parameter int SLOTS_PER_ZONE = 2,
	parameter int MAX_DETECTORS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [zot_pkg::TDATA_IN_W-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [zot_pkg::TDATA_OUT_W-1:0]  m_tdata,
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic                             cfg_addr,
	input  logic [zot_pkg::CFG_W-1:0]        cfg_wdata,
	input  zot_pkg::cmd_t                    cmd,
	output zot_pkg::sts_t                    sts
);
	import zot_pkg::*;

	localparam int ZW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int SW    = (SLOTS_PER_ZONE > 1) ? $clog2(SLOTS_PER_ZONE) : 1;
	localparam int NMAP  = MAX_ZONES * SLOTS_PER_ZONE;
	localparam int MW    = (NMAP > 1) ? $clog2(NMAP) : 1;
	localparam int NZW   = $clog2(MAX_ZONES + 1);
	localparam int SUMW  = $clog2(MAX_ZONES * 2047 + 1);
	localparam logic [6:0]    CODE_MAX = 7'(2 * MAX_DETECTORS);
	localparam logic [NZW:0]  NZ_MAX   = (NZW + 1)'(MAX_ZONES);
	localparam logic [SW-1:0] SLOT_TOP = SW'(SLOTS_PER_ZONE - 1);

	// input fields
	logic [5:0]       f_code;
	logic [2:0]       f_zone;
	logic             f_slot;
	logic             f_kind;
	logic [4:0]       f_did;
	logic [9:0]       f_val;
	assign f_code = s_tdata[5:0];
	assign f_zone = s_tdata[8:6];
	assign f_slot = s_tdata[9];
	assign f_kind = s_tdata[10];
	assign f_did  = s_tdata[15:11];
	assign f_val  = s_tdata[25:16];

	logic             zone_ok;
	logic             slot_ok;
	logic [ZW-1:0]    ld_zone;
	logic [MW-1:0]    ld_idx;
	assign zone_ok = (int'(f_zone) < MAX_ZONES);
	assign slot_ok = (int'(f_slot) < SLOTS_PER_ZONE);
	assign ld_zone = ZW'(int'(f_zone));
	assign ld_idx  = MW'(int'(f_zone) * SLOTS_PER_ZONE + int'(f_slot));

	// configuration
	logic [12:0] level_cap_q;
	logic [3:0]  zone_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_cap_q <= '0;
			zone_cnt_q  <= 4'd1;
		end else if (cfg_we) begin
			if (cfg_addr == CFG_LEVEL_CAP) level_cap_q <= cfg_wdata;
			else                           zone_cnt_q  <= cfg_wdata[3:0];
		end
	end

	logic [NZW:0] nz;
	assign nz = (int'(zone_cnt_q) > MAX_ZONES) ? NZ_MAX : (NZW + 1)'(zone_cnt_q);

	// event decode
	logic       fwd_q;
	logic [5:0] det_q;
	logic [6:0] code_p1;
	assign code_p1   = {1'b0, f_code} + 7'd1;
	assign sts.ev_ok = (s_tuser == MODE_EVENT) && (f_code != '0)
		&& ({1'b0, f_code} <= CODE_MAX);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fwd_q <= f_code[0];
			det_q <= f_code[0] ? code_p1[6:1] : {1'b0, f_code[5:1]};
		end
	end

	// scan counters and level sum
	logic [ZW-1:0]   zc_q;
	logic [SW-1:0]   sc_q;
	logic [SUMW-1:0] sum_q;
	logic [MW-1:0]   scan_idx;
	assign scan_idx = MW'(int'(zc_q) * SLOTS_PER_ZONE + int'(sc_q));

	// stores
	logic [OCC_W-1:0] occ_q   [MAX_ZONES];
	logic [CAP_W-1:0] cap_q   [MAX_ZONES];
	logic [MAP_W-1:0] entry_q [NMAP];
	logic [MAP_W-1:0] exit_q  [NMAP];

	logic [MAP_W-1:0] map_val;
	logic [OCC_W-1:0] occ_cur;
	logic [OCC_W-1:0] occ_new;
	logic             add;
	assign map_val = cmd.exit_sel ? exit_q[scan_idx] : entry_q[scan_idx];
	assign occ_cur = occ_q[zc_q];
	assign add     = fwd_q ^ cmd.exit_sel;

	always_comb begin
		if (add) occ_new = (occ_cur == OCC_MAX) ? occ_cur : occ_cur + 1'b1;
		else     occ_new = (occ_cur == '0) ? occ_cur : occ_cur - 1'b1;
	end

	assign sts.match    = ({1'b0, map_val} == det_q);
	assign sts.zone_end = (int'(zc_q) == int'(nz) - 1);
	assign sts.scan_end = sts.zone_end && (sc_q == SLOT_TOP);
	assign sts.nz_zero  = (nz == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zc_q  <= '0;
			sc_q  <= '0;
			sum_q <= '0;
		end else if (cmd.ctr_clr) begin
			zc_q  <= '0;
			sc_q  <= '0;
			sum_q <= '0;
		end else if (cmd.slot_adv) begin
			if (sc_q == SLOT_TOP) begin
				sc_q <= '0;
				zc_q <= zc_q + 1'b1;
			end else begin
				sc_q <= sc_q + 1'b1;
			end
		end else if (cmd.zone_adv) begin
			zc_q  <= zc_q + 1'b1;
			sum_q <= sum_q + SUMW'(occ_cur);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ZONES; i++) begin
				occ_q[i] <= '0;
				cap_q[i] <= '0;
			end
			for (int i = 0; i < NMAP; i++) begin
				entry_q[i] <= '0;
				exit_q[i]  <= '0;
			end
		end else begin
			if (cmd.capture && zone_ok) begin
				if (s_tuser == MODE_MAP && slot_ok) begin
					if (f_kind) exit_q[ld_idx]  <= f_did;
					else        entry_q[ld_idx] <= f_did;
				end
				if (s_tuser == MODE_CAP) cap_q[ld_zone] <= f_val;
				if (s_tuser == MODE_OCC) occ_q[ld_zone] <= OCC_W'(f_val);
			end
			if (cmd.occ_upd) occ_q[zc_q] <= occ_new;
		end
	end

	// output register
	cls_t zone_cls;
	cls_t level_cls;
	assign zone_cls  = classify(CLS_W'(cap_q[zc_q]), CLS_W'(occ_new));
	assign level_cls = classify(CLS_W'(level_cap_q), CLS_W'(sum_q));

	logic             out_v_q;
	logic [1:0]       o_kind_q;
	logic             o_dir_q;
	logic [4:0]       o_det_q;
	logic [2:0]       o_zone_q;
	logic [1:0]       o_st_q;
	logic [12:0]      o_fc_q;

	logic             o_dir_d;
	logic [4:0]       o_det_d;
	logic [2:0]       o_zone_d;
	logic [1:0]       o_st_d;
	logic [12:0]      o_fc_d;

	assign sts.out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_comb begin
		o_dir_d  = 1'b0;
		o_det_d  = '0;
		o_zone_d = '0;
		o_st_d   = ST_AVAIL;
		o_fc_d   = '0;
		unique case (cmd.kind)
			KIND_ECHO: begin
				o_dir_d = !fwd_q;
				o_det_d = det_q[4:0];
			end
			KIND_ZONE: begin
				o_zone_d = 3'(zc_q);
				o_st_d   = zone_cls.st;
				o_fc_d   = zone_cls.fc;
			end
			KIND_LEVEL: begin
				o_st_d = level_cls.st;
				o_fc_d = level_cls.fc;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_kind_q <= cmd.kind;
			o_dir_q  <= o_dir_d;
			o_det_q  <= o_det_d;
			o_zone_q <= o_zone_d;
			o_st_q   <= o_st_d;
			o_fc_q   <= o_fc_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = (o_kind_q == KIND_LEVEL);
	assign m_tdata  = {o_fc_q, o_st_q, o_zone_q, o_det_q, o_dir_q};

endmodule

// ----- design/zone_occupancy_tracker.sv -----
// ----------------------------------------------------------------------------
// zone_occupancy_tracker
// Parking level occupancy from directional detector events.
// ----------------------------------------------------------------------------
// A load item (map slot, zone capacity, preset occupancy) is taken while idle
// and gives no beats. For a detector event the sequencer reads one map slot
// per cycle in the entry and exit scans, holding on a matching slot while the
// output register cannot take a beat, then adds one zone occupancy per cycle.
// It emits an echo beat, one zone beat per matching slot and a level beat
// with tlast set. The output register lets the next item be taken while the
// final beat still waits. All stores are cleared by reset, with no sweep.
// ----------------------------------------------------------------------------
module zone_occupancy_tracker #(
	parameter int MAX_ZONES      = 8,
	parameter int SLOTS_PER_ZONE = 2,
	parameter int MAX_DETECTORS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// event_code[5:0], zone[8:6], slot[9], slot_kind[10], detector_id[15:11],
	// load_value[25:16], zero fill above
	input  logic [zot_pkg::TDATA_IN_W-1:0]   s_tdata,
	// mode[1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// direction[0], detector[5:1], report_zone[8:6], status[10:9],
	// free_count[23:11]
	output logic [zot_pkg::TDATA_OUT_W-1:0]  m_tdata,
	// report_kind[1:0]
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic                             cfg_addr,
	input  logic [zot_pkg::CFG_W-1:0]        cfg_wdata
);
	import zot_pkg::*;

	cmd_t cmd;
	sts_t sts;

	zot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	zot_dp #(
		.MAX_ZONES      (MAX_ZONES),
		.SLOTS_PER_ZONE (SLOTS_PER_ZONE),
		.MAX_DETECTORS  (MAX_DETECTORS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	// load items never hold off the next beat
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != MODE_EVENT |=> s_tready)
		else $error("load item stalled the input");

	// free count only accompanies the spaces-available status
	a_free_only_avail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10:9] != ST_AVAIL |-> m_tdata[23:11] == '0)
		else $error("free count on full or empty report");

	// a zone update always goes out together with its zone report
	a_upd_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.occ_upd |-> cmd.emit && cmd.kind == KIND_ZONE && sts.out_free)
		else $error("occupancy changed without a zone report");

	// a usable event starts a run, so the input drops ready once it is accepted
	a_echo_first: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && sts.ev_ok |=> !s_tready)
		else $error("event accepted without starting a run");

endmodule
